[src/array_priority_queue_macros.svh]
// ----------------------------------------------------------------------------
// array_priority_queue_macros.svh
// Assertion macros shared by the priority queue modules.
// ----------------------------------------------------------------------------
`ifndef ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define APQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define APQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// invariant on every cycle out of reset
`define APQ_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`else

`define APQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define APQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`define APQ_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)

`endif

`endif

[src/apq_pkg.sv]
// ----------------------------------------------------------------------------
// apq_pkg
// Sizes, status codes and controller/datapath command types of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PRIO_W = 8;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic              load;        // capture the request beat
      logic              ins;         // append captured pair
      logic              scan_init;   // start scan at slot 0
      logic              rd_en;       // read entry store at walk index
      logic              cmp;         // compare read entry against best
      logic              shift_init;  // start shift just above the pick
      logic              shift_wr;    // write read entry one slot down
      logic              cnt_dec;     // drop one entry from the count
      logic              rsp_load;    // load the result register
      logic [STAT_W-1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic op_remove;
      logic full;
      logic empty;
      logic idx_last;   // walk index sits on the last held entry
      logic pick_last;  // chosen entry is the last held entry
   } dp_sts_type;

endpackage

[src/apq_if.sv]
// ----------------------------------------------------------------------------
// apq_if
// Valid/ready channels for request and response beats of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic        [apq_pkg::PRIO_W-1:0]   priority_req;
   logic signed [apq_pkg::DATA_W-1:0]   payload;

   modport source (output valid, op, priority_req, payload, input ready);
   modport sink   (input valid, op, priority_req, payload, output ready);
endinterface

interface apq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [apq_pkg::STAT_W-1:0]   status;
   logic        [apq_pkg::PRIO_W-1:0]   out_priority;
   logic signed [apq_pkg::DATA_W-1:0]   out_payload;

   modport source (output valid, status, out_priority, out_payload, input ready);
   modport sink   (input valid, status, out_priority, out_payload, output ready);
endinterface

[src/apq_dp.sv]
// ----------------------------------------------------------------------------
// apq_dp
// Datapath: entry store, count, scan for the first maximum, shift-down walk
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "array_priority_queue_macros.svh"

module apq_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_op,
   input  logic        [apq_pkg::PRIO_W-1:0] req_priority,
   input  logic signed [apq_pkg::DATA_W-1:0] req_payload,
   input  apq_pkg::dp_cmd_type               cmd,
   output apq_pkg::dp_sts_type               sts,
   output logic        [apq_pkg::STAT_W-1:0] rsp_status,
   output logic        [apq_pkg::PRIO_W-1:0] rsp_priority,
   output logic signed [apq_pkg::DATA_W-1:0] rsp_payload
);

   // entry store
   logic [apq_pkg::PRIO_W-1:0] mem_prio [apq_pkg::DEPTH];
   logic [apq_pkg::DATA_W-1:0] mem_data [apq_pkg::DEPTH];

   // captured request
   logic                       op_ff;
   logic [apq_pkg::PRIO_W-1:0] prio_ff;
   logic [apq_pkg::DATA_W-1:0] data_ff;

   logic [apq_pkg::CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [apq_pkg::IDX_W-1:0]  idx_ff,  idx_in;
   logic                       rd_vld_ff;
   logic [apq_pkg::IDX_W-1:0]  rd_idx_ff;
   logic [apq_pkg::PRIO_W-1:0] rd_prio_ff;
   logic [apq_pkg::DATA_W-1:0] rd_data_ff;

   logic [apq_pkg::PRIO_W-1:0] best_prio_ff;
   logic [apq_pkg::DATA_W-1:0] best_data_ff;
   logic [apq_pkg::IDX_W-1:0]  pick_ff;

   logic [apq_pkg::STAT_W-1:0] rsp_status_ff;
   logic [apq_pkg::PRIO_W-1:0] rsp_prio_ff;
   logic [apq_pkg::DATA_W-1:0] rsp_data_ff;

   logic                       take;
   logic                       wr_en;
   logic [apq_pkg::IDX_W-1:0]  wr_addr;
   logic [apq_pkg::PRIO_W-1:0] wr_prio;
   logic [apq_pkg::DATA_W-1:0] wr_data;
   logic [apq_pkg::CNT_W-1:0]  last_slot;

   assign last_slot = cnt_ff - apq_pkg::CNT_W'(1);

   // slot 0 is always taken so an all-zero queue returns its oldest entry
   assign take = cmd.cmp & rd_vld_ff &
                 ((rd_idx_ff == '0) | (rd_prio_ff > best_prio_ff));

   always_comb begin
      wr_en   = cmd.ins | (cmd.shift_wr & rd_vld_ff);
      wr_addr = cmd.ins ? cnt_ff[apq_pkg::IDX_W-1:0] : rd_idx_ff - apq_pkg::IDX_W'(1);
      wr_prio = cmd.ins ? prio_ff : rd_prio_ff;
      wr_data = cmd.ins ? data_ff : rd_data_ff;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.ins) begin
         cnt_in = cnt_ff + apq_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - apq_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      priority if (cmd.scan_init) begin
         idx_in = '0;
      end else if (cmd.shift_init) begin
         idx_in = pick_ff + apq_pkg::IDX_W'(1);
      end else if (cmd.rd_en) begin
         idx_in = idx_ff + apq_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_vld_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         op_ff   <= req_op;
         prio_ff <= req_priority;
         data_ff <= $unsigned(req_payload);
      end
      if (take) begin
         best_prio_ff <= rd_prio_ff;
         best_data_ff <= rd_data_ff;
         pick_ff      <= rd_idx_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         if (cmd.rsp_status == apq_pkg::ST_REMOVED) begin
            rsp_prio_ff <= best_prio_ff;
            rsp_data_ff <= best_data_ff;
         end else begin
            rsp_prio_ff <= '0;
            rsp_data_ff <= '0;
         end
      end
   end

   // entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_prio[wr_addr] <= wr_prio;
         mem_data[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_prio_ff <= mem_prio[idx_ff];
         rd_data_ff <= mem_data[idx_ff];
         rd_idx_ff  <= idx_ff;
      end
   end

   assign sts.op_remove = (op_ff == apq_pkg::OP_REMOVE);
   assign sts.full      = (cnt_ff == apq_pkg::CNT_W'(apq_pkg::DEPTH));
   assign sts.empty     = (cnt_ff == '0);
   assign sts.idx_last  = (apq_pkg::CNT_W'(idx_ff) == last_slot);
   assign sts.pick_last = (apq_pkg::CNT_W'(pick_ff) == last_slot);

   assign rsp_status   = rsp_status_ff;
   assign rsp_priority = rsp_prio_ff;
   assign rsp_payload  = $signed(rsp_data_ff);

   `APQ_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= apq_pkg::CNT_W'(apq_pkg::DEPTH), "entry count beyond depth")
   `APQ_ASSERT_IMP(a_rd_held, clock, reset, cmd.rd_en, apq_pkg::CNT_W'(idx_ff) < cnt_ff, "read past held")
   `APQ_ASSERT_IMP(a_shift_dst, clock, reset, cmd.shift_wr && rd_vld_ff, rd_idx_ff != '0, "shift below slot 0")
   `APQ_ASSERT_IMP(a_dec_held, clock, reset, cmd.cnt_dec, !sts.empty, "removal from an empty store")

endmodule

[src/apq_ctrl.sv]
// ----------------------------------------------------------------------------
// apq_ctrl
// Controller: sequences insert, scan and shift-down, and owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "array_priority_queue_macros.svh"

module apq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  apq_pkg::dp_sts_type sts,
   output apq_pkg::dp_cmd_type cmd
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_EXEC       = 3'd1;
   localparam logic [2:0] S_SCAN       = 3'd2;
   localparam logic [2:0] S_SCAN_END   = 3'd3;
   localparam logic [2:0] S_SHIFT_INIT = 3'd4;
   localparam logic [2:0] S_SHIFT      = 3'd5;
   localparam logic [2:0] S_SHIFT_END  = 3'd6;

   logic [2:0] state_ff,  state_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       slot_free;

   assign slot_free = !rsp_vld_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.op_remove && !sts.empty) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
               priority if (sts.op_remove) begin
                  cmd.rsp_status = apq_pkg::ST_EMPTY;
               end else if (sts.full) begin
                  cmd.rsp_status = apq_pkg::ST_FULL;
               end else begin
                  cmd.ins        = 1'b1;
                  cmd.rsp_status = apq_pkg::ST_INSERTED;
               end
            end
         end
         S_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.cmp   = 1'b1;
            if (sts.idx_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            cmd.cmp  = 1'b1;
            state_in = S_SHIFT_INIT;
         end
         S_SHIFT_INIT: begin
            if (!sts.pick_last) begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT;
            end else if (slot_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = apq_pkg::ST_REMOVED;
               cmd.cnt_dec    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_SHIFT: begin
            cmd.rd_en    = 1'b1;
            cmd.shift_wr = 1'b1;
            if (sts.idx_last) begin
               state_in = S_SHIFT_END;
            end
         end
         S_SHIFT_END: begin
            // last write lands on the first cycle; hold here while the result slot is busy
            cmd.shift_wr = 1'b1;
            if (slot_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = apq_pkg::ST_REMOVED;
               cmd.cnt_dec    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_vld_in = cmd.rsp_load || (rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;

   `APQ_ASSERT_IMP(a_load_free, clock, reset, cmd.rsp_load, !rsp_vld_ff || rsp_ready, "result overwritten while pending")
   `APQ_ASSERT_IMP(a_ins_room, clock, reset, cmd.ins, !sts.full, "append into a full store")
   `APQ_ASSERT_NXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == S_EXEC, "accepted beat not executed")
   `APQ_ASSERT_ALWAYS(a_one_update, clock, reset, $onehot0({cmd.ins, cmd.scan_init, cmd.shift_init, cmd.cnt_dec}), "conflicting store updates")

endmodule

[src/array_priority_queue.sv]
// ----------------------------------------------------------------------------
// array_priority_queue
// Bounded priority queue over an unsorted entry store kept in arrival order.
//
// req_chan carries beats with op (0 insert, 1 remove), priority_req and
// payload; rsp_chan returns one beat per request with status (0 inserted,
// 1 removed, 2 full, 3 empty), out_priority and out_payload (zero unless
// an entry was removed). Both use valid/ready.
// Insert, full and empty: the result is loaded in the execute state that
// follows the accept. Remove scans every held slot for the oldest maximum
// and, unless that entry is the last held one, shifts the entries above
// it down one slot; the entry store has a single read port, so the scan
// reads one slot a cycle and the shift-down moves one slot a cycle.
// One request is in flight at a time; a new beat can be taken in the cycle
// after the previous result is loaded, even while that result still waits.
// Reset empties the queue; the store itself is not cleared.
// A stalled receiver holds the result; the block finishes its work and then
// waits with the next result until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_priority_queue (
   input  logic      clock,
   input  logic      reset,
   apq_req_if.sink   req_chan,
   apq_rsp_if.source rsp_chan
);

   apq_pkg::dp_cmd_type cmd;
   apq_pkg::dp_sts_type sts;

   apq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   apq_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_chan.op),
      .req_priority (req_chan.priority_req),
      .req_payload  (req_chan.payload),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_status   (rsp_chan.status),
      .rsp_priority (rsp_chan.out_priority),
      .rsp_payload  (rsp_chan.out_payload)
   );

endmodule
